// ===== rtl/rgbpal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB565 palette package
// Shared constants, transaction types and helpers for the palette builder.
// ----------------------------------------------------------------------------
package rgbpal_pkg;

    // Palette size and the widths that follow from it.
    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

    // Command codes.
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LEARN = 2'd1;
    localparam logic [1:0] CMD_MAP   = 2'd2;

    // Input transaction.
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    // Output transaction.
    typedef struct packed {
        logic [15:0] color565;
        logic [7:0]  palette_index;
        logic        palette_active;
        logic [8:0]  color_count;
    } t_out_item;

    // Token that walks down the cell chain during a lookup.
    typedef struct packed {
        logic             vld;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_scan_tok;

    // Broadcast write into one palette cell.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [15:0]      data;
    } t_wr_req;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    // Truncate an RGB888 pixel to RGB565.
    function automatic logic [15:0] to565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

// ===== rtl/rgbpal_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette cell
// Holds one palette entry, compares it with the lookup key as the scan token
// passes, and registers the token toward the next cell.
// ----------------------------------------------------------------------------
module rgbpal_cell
    import rgbpal_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [15:0]      i_key,
    input  logic [CNT_W-1:0] i_count,
    input  t_wr_req          i_wr,
    input  t_scan_tok        i_tok,
    output t_scan_tok        o_tok
);

    logic [15:0] r_entry;
    t_scan_tok   r_tok;
    t_scan_tok   n_tok;
    logic        w_live;
    logic        w_match;

    // The entry takes part only when it lies below the fill count.
    assign w_live  = CNT_W'(i_idx) < i_count;
    assign w_match = w_live && (r_entry == i_key);

    // Merge this cell's result into the passing token.
    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && w_match) begin
            n_tok.hit = 1'b1;
            n_tok.idx = i_idx;
        end
    end

    // Entry storage; written only when the broadcast address is this cell.
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.addr == i_idx)) begin
            r_entry <= i_wr.data;
        end
    end

    // Token stage toward the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/rgbpal_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette cell chain
// A row of PALETTE_DEPTH cells; the scan token enters at cell zero, passes through
// each cell's token register in turn and leaves the last cell with the match result.
// ----------------------------------------------------------------------------
module rgbpal_chain
    import rgbpal_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [15:0]      i_key,
    input  logic [CNT_W-1:0] i_count,
    input  t_wr_req          i_wr,
    input  t_scan_tok        i_tok,
    output t_scan_tok        o_tok
);

    t_scan_tok w_link [PALETTE_DEPTH+1];

    assign w_link[0] = i_tok;

    // Link the cells head to tail.
    for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
        rgbpal_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_key   (i_key),
            .i_count (i_count),
            .i_wr    (i_wr),
            .i_tok   (w_link[g]),
            .o_tok   (w_link[g+1])
        );
    end

    assign o_tok = w_link[PALETTE_DEPTH];

endmodule

// ===== rtl/rgb565_palette_builder_indexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow: clear, unknown commands and any command after overflow pass from the input
// transaction through the FIN state to the output register; learn and map first
// run a scan token down the cell chain. Output stalls hold the item in FIN.
// Items go one at a time: a new one is accepted the cycle after the previous result
// is registered. Reset (synchronous, active low) empties the palette count and
// clears overflow; entries are not cleared.
// ----------------------------------------------------------------------------
// RGB565 palette builder and indexer
// Truncates RGB888 pixels to RGB565, builds a palette of distinct colors and
// maps pixels to palette indexes, falling back to raw RGB565 on overflow.
// ----------------------------------------------------------------------------
module rgb565_palette_builder_indexer
    import rgbpal_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_state           r_state;
    t_state           n_state;
    logic [1:0]       r_cmd;
    logic [15:0]      r_color;
    logic             r_launch;
    logic             r_hit;
    logic [IDX_W-1:0] r_hidx;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ovf;
    logic             n_ovf;
    t_out_item        r_out;
    t_out_item        n_out;
    logic             r_out_vld;
    t_wr_req          w_wr;
    t_scan_tok        w_head;
    t_scan_tok        w_tail;
    logic             w_in_fire;
    logic             w_need_scan;
    logic             w_out_free;
    logic             w_fin_fire;

    // Handshake qualifiers.
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_need_scan = ((i_in_data.command == CMD_LEARN) ||
                          (i_in_data.command == CMD_MAP)) && !r_ovf;
    assign w_out_free  = !r_out_vld || i_out_ready;
    assign w_fin_fire  = (r_state == ST_FIN) && w_out_free;

    // Scan token launched into the head of the chain.
    assign w_head.vld = r_launch;
    assign w_head.hit = 1'b0;
    assign w_head.idx = '0;

    rgbpal_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (r_color),
        .i_count (r_count),
        .i_wr    (w_wr),
        .i_tok   (w_head),
        .o_tok   (w_tail)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_state = w_need_scan ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN: begin
                if (w_tail.vld) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result and state update, applied when the sequencer finishes an item.
    always_comb begin
        n_count                = r_count;
        n_ovf                  = r_ovf;
        n_out.color565         = r_color;
        n_out.palette_index    = '0;
        n_out.palette_active   = 1'b0;
        w_wr.en                = 1'b0;
        w_wr.addr              = r_count[IDX_W-1:0];
        w_wr.data              = r_color;
        case (r_cmd)
            CMD_CLEAR: begin
                n_count              = '0;
                n_ovf                = 1'b0;
                n_out.palette_active = 1'b1;
            end
            CMD_LEARN: begin
                if (!r_ovf) begin
                    if (r_hit) begin
                        n_out.palette_index  = 8'(r_hidx);
                        n_out.palette_active = 1'b1;
                    end else if (r_count >= CNT_W'(PALETTE_DEPTH)) begin
                        // A new color with a full palette gives the palette up.
                        n_ovf   = 1'b1;
                        n_count = '0;
                    end else begin
                        w_wr.en              = w_fin_fire;
                        n_out.palette_index  = 8'(r_count);
                        n_out.palette_active = 1'b1;
                        n_count              = CNT_W'(r_count + CNT_W'(1));
                    end
                end
            end
            CMD_MAP: begin
                if (!r_ovf && r_hit) begin
                    n_out.palette_index  = 8'(r_hidx);
                    n_out.palette_active = 1'b1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out.color_count = 9'(n_count);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_launch  <= 1'b0;
            r_hit     <= 1'b0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_in_fire && w_need_scan;
            if (w_in_fire) begin
                r_hit <= 1'b0;
            end else if ((r_state == ST_SCAN) && w_tail.vld) begin
                r_hit <= w_tail.hit;
            end
            if (w_fin_fire) begin
                r_count   <= n_count;
                r_ovf     <= n_ovf;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cmd   <= i_in_data.command;
            r_color <= to565(i_in_data.red, i_in_data.green, i_in_data.blue);
        end
        if ((r_state == ST_SCAN) && w_tail.vld) begin
            r_hidx <= w_tail.idx;
        end
        if (w_fin_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== tb/rgb565_palette_builder_indexer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB565 palette builder and indexer testbench
// Sends pixel transactions with clear, learn, map and undefined commands. A
// behavioral palette tracker predicts each result, and every output
// transaction is checked field by field. The stimulus fills the palette
// partly, exactly to its depth and past it, with random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module rgb565_palette_builder_indexer_test;
    import rgbpal_pkg::*;

    // The one command code that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int ITEM_TARGET  = 1650;
    localparam int DRAIN_CYCLES = PALETTE_DEPTH + 40;

    // How far one learn sequence fills the palette.
    typedef enum {
        FILL_SOME,
        FILL_EXACT,
        FILL_PAST
    } t_fill;

    // Tracks palette contents and holds the results still to come.
    class palette_tracker;
        logic [15:0] colors [PALETTE_DEPTH];
        int unsigned count;
        bit          overflowed;
        t_out_item   pending_results [$];
        int          errors;

        function new();
            count      = 0;
            overflowed = 1'b0;
            errors     = 0;
        endfunction

        // Searches the stored entries, newest first.
        function bit find(input logic [15:0] color, output int unsigned idx);
            idx = 0;
            for (int i = int'(count) - 1; i >= 0; i--) begin
                if (colors[i] == color) begin
                    idx = i;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // Applies one accepted pixel and queues the result it causes.
        function void note_pixel(input t_in_item px);
            logic [15:0] color;
            int unsigned idx;
            bit          active;
            t_out_item   res;
            color  = {px.red[7:3], px.green[7:2], px.blue[7:3]};
            idx    = 0;
            active = 1'b0;
            case (px.command)
                CMD_CLEAR: begin
                    count      = 0;
                    overflowed = 1'b0;
                    active     = 1'b1;
                end
                CMD_LEARN: begin
                    if (!overflowed) begin
                        if (find(color, idx)) begin
                            active = 1'b1;
                        end else if (count >= PALETTE_DEPTH) begin
                            // A new color with no room left gives the palette up.
                            overflowed = 1'b1;
                            count      = 0;
                            idx        = 0;
                        end else begin
                            idx           = count;
                            colors[count] = color;
                            count++;
                            active = 1'b1;
                        end
                    end
                end
                CMD_MAP: begin
                    if (!overflowed && find(color, idx)) begin
                        active = 1'b1;
                    end else begin
                        idx = 0;
                    end
                end
                default: ;
            endcase
            res.color565       = color;
            res.palette_index  = idx[7:0];
            res.palette_active = active;
            res.color_count    = count[8:0];
            pending_results.push_back(res);
        endfunction

        function void compare(input string field, input logic [15:0] want,
                              input logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        // Checks one output transaction against the oldest prediction.
        function void check_result(input t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare("color565", want.color565, got.color565);
            compare("palette_index", 16'(want.palette_index), 16'(got.palette_index));
            compare("palette_active", 16'(want.palette_active), 16'(got.palette_active));
            compare("color_count", 16'(want.color_count), 16'(got.color_count));
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int items_sent      = 0;

    palette_tracker tracker = new();

    rgb565_palette_builder_indexer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Free-running clock.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // The receiver stalls at random.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Every accepted output transaction is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_result(o_out_data);
        end
    end

    function automatic t_in_item random_pixel(input logic [1:0] cmd);
        t_in_item px;
        px.command = cmd;
        px.red     = 8'($urandom);
        px.green   = 8'($urandom);
        px.blue    = 8'($urandom);
        return px;
    endfunction

    // A pixel of a stored color, with random values in the dropped low bits.
    function automatic t_in_item known_pixel(input logic [1:0] cmd);
        t_in_item    px;
        logic [15:0] color;
        px          = random_pixel(cmd);
        color       = tracker.colors[$urandom_range(0, tracker.count - 1)];
        px.red[7:3]   = color[15:11];
        px.green[7:2] = color[10:5];
        px.blue[7:3]  = color[4:0];
        return px;
    endfunction

    // Sends one input transaction, with idling set by the phase of the run.
    task automatic send_pixel(input t_in_item px);
        case ((items_sent * 4) / ITEM_TARGET)
            0: begin
                sender_idle_pct = 0;
                stall_pct       = 0;
            end
            1: begin
                sender_idle_pct = 51;
                stall_pct       = 0;
            end
            2: begin
                sender_idle_pct = 0;
                stall_pct       = 51;
            end
            default: begin
                sender_idle_pct = 31;
                stall_pct       = 31;
            end
        endcase
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_pixel(px);
        items_sent++;
    endtask

    // Usually one clear, then a learn sequence and a run of lookups, with some noise.
    task automatic run_episode(input int ep);
        t_fill       fill;
        int unsigned goal;
        int          roll;
        int          extra;
        int          maps;
        fill = (ep % 5 == 1) ? FILL_EXACT : (ep % 5 == 3) ? FILL_PAST : FILL_SOME;
        if ($urandom_range(0, 9) != 0) begin
            send_pixel(random_pixel(CMD_CLEAR));
        end
        goal  = (fill == FILL_SOME) ? $urandom_range(1, 40) : PALETTE_DEPTH;
        extra = (fill == FILL_PAST) ? $urandom_range(1, 4) : 0;

        // Learn until the goal is reached, or past the depth into overflow.
        while (!tracker.overflowed && (tracker.count < goal || fill == FILL_PAST)) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                send_pixel(random_pixel(CMD_UNUSED));
            end else if (roll < 7 && tracker.count > 0) begin
                send_pixel(known_pixel(CMD_MAP));
            end else if (roll < 15 && tracker.count > 0) begin
                send_pixel(known_pixel(CMD_LEARN));
            end else begin
                send_pixel(random_pixel(CMD_LEARN));
            end
        end

        // Learns after overflow are ignored.
        repeat (extra) send_pixel(random_pixel(CMD_LEARN));

        maps = $urandom_range(4, 30);
        repeat (maps) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                send_pixel(random_pixel(CMD_UNUSED));
            end else if (roll < 10) begin
                send_pixel(random_pixel(CMD_LEARN));
            end else if (roll < 60 && tracker.count > 0) begin
                send_pixel(known_pixel(CMD_MAP));
            end else begin
                send_pixel(random_pixel(CMD_MAP));
            end
        end
    endtask

    // Main sequence: reset, directed pixels, random episodes, drain.
    initial begin
        int ep;
        ep = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes, truncation aliases and each command.
        send_pixel('{CMD_CLEAR, 8'h00, 8'h00, 8'h00});
        send_pixel('{CMD_LEARN, 8'h00, 8'h00, 8'h00});
        send_pixel('{CMD_LEARN, 8'hFF, 8'hFF, 8'hFF});
        send_pixel('{CMD_LEARN, 8'h07, 8'h03, 8'h07});
        send_pixel('{CMD_LEARN, 8'h08, 8'h00, 8'h00});
        send_pixel('{CMD_LEARN, 8'h00, 8'h04, 8'h00});
        send_pixel('{CMD_LEARN, 8'h00, 8'h00, 8'h08});
        send_pixel('{CMD_MAP, 8'hF8, 8'hFC, 8'hF8});
        send_pixel('{CMD_MAP, 8'h07, 8'h03, 8'h07});
        send_pixel('{CMD_MAP, 8'h10, 8'h00, 8'h00});
        send_pixel('{CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF});
        send_pixel('{CMD_MAP, 8'h00, 8'h00, 8'h08});
        send_pixel('{CMD_LEARN, 8'hF0, 8'hF0, 8'hF0});
        send_pixel('{CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF});
        send_pixel('{CMD_MAP, 8'h00, 8'h00, 8'h00});
        send_pixel('{CMD_LEARN, 8'h00, 8'h00, 8'h00});
        send_pixel('{CMD_UNUSED, 8'h00, 8'h00, 8'h00});

        // Random episodes until enough pixels have gone in.
        while (items_sent < ITEM_TARGET) begin
            run_episode(ep);
            ep++;
        end

        i_in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #60ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rgbpal_pkg.sv
rtl/rgbpal_cell.sv
rtl/rgbpal_chain.sv
rtl/rgb565_palette_builder_indexer.sv
tb/rgb565_palette_builder_indexer_test.sv
